@@ rtl/core/owbm_pkg.sv @@
// shared types and constants of the 1-wire bus master
`timescale 1ns / 1ps

package owbm_pkg;

  localparam int unsigned CFG_W     = 10;
  localparam int unsigned CFG_NUM   = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned BYTE_W    = 8;

  typedef logic [CFG_W-1:0]     cfg_word_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [OP_W-1:0]      op_code_t;
  typedef logic [BYTE_W-1:0]    byte_t;

  // operation codes on the item channel
  localparam op_code_t OP_NONE       = 3'd0;
  localparam op_code_t OP_RESET      = 3'd1;
  localparam op_code_t OP_WRITE      = 3'd2;
  localparam op_code_t OP_READ       = 3'd3;
  localparam op_code_t OP_RESET_SKIP = 3'd4;

  // register indexes
  localparam cfg_idx_t REG_RESET_LOW      = 3'd0;
  localparam cfg_idx_t REG_PRESENCE_SMP   = 3'd1;
  localparam cfg_idx_t REG_RESET_TAIL     = 3'd2;
  localparam cfg_idx_t REG_SHORT_LOW      = 3'd3;
  localparam cfg_idx_t REG_WRITE_ONE_TAIL = 3'd4;
  localparam cfg_idx_t REG_WRITE_ZERO_LOW = 3'd5;
  localparam cfg_idx_t REG_WRITE_ZERO_TL  = 3'd6;
  localparam cfg_idx_t REG_READ_SAMPLE    = 3'd7;

  localparam cfg_word_t CFG_RESET [CFG_NUM] = '{
    10'd480, 10'd70, 10'd410, 10'd6, 10'd64, 10'd60, 10'd10, 10'd9
  };

  localparam cfg_word_t READ_TAIL_US  = 10'd55;
  localparam byte_t     SKIP_ROM_CODE = 8'hCC;

  // decoded command class
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_RESET,
    CMD_WRITE,
    CMD_READ,
    CMD_RESET_SKIP
  } cmd_t;

  // one queued item
  typedef struct packed {
    logic  tick;
    logic  line_level;
    cmd_t  cmd;
    byte_t data_byte;
  } item_t;

endpackage

@@ rtl/core/owbm_if.sv @@
// handshake channels of the 1-wire bus master
`timescale 1ns / 1ps

interface owbm_in_if
  import owbm_pkg::*;
  ();
  logic     valid;
  logic     ready;
  logic     tick;
  logic     line_level;
  op_code_t operation;
  byte_t    data_byte;

  modport source (output valid, tick, line_level, operation, data_byte, input ready);
  modport sink   (input valid, tick, line_level, operation, data_byte, output ready);
endinterface

interface owbm_out_if
  import owbm_pkg::*;
  ();
  logic  valid;
  logic  ready;
  logic  drive_low;
  logic  busy_res;
  logic  done_res;
  byte_t received_byte;
  logic  no_presence;

  modport source (output valid, drive_low, busy_res, done_res, received_byte, no_presence,
                  input ready);
  modport sink   (input valid, drive_low, busy_res, done_res, received_byte, no_presence,
                  output ready);
endinterface

interface owbm_cfg_if
  import owbm_pkg::*;
  ();
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_word_t data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/owbm_front.sv @@
// front end: accepts items, decodes the operation and queues them
`timescale 1ns / 1ps

module owbm_front
  import owbm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  owbm_in_if.sink   item,
  output logic      q_valid,
  output item_t     q_item,
  input  logic      pop
);

  item_t      entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  item_t      decoded;

  assign item.ready = (count != 2'd2);
  assign push       = item.valid && item.ready;
  assign q_valid    = (count != 2'd0);
  assign q_item     = entries[rd_ptr];

  // codes beyond the list behave as no operation
  always_comb begin
    decoded.tick       = item.tick;
    decoded.line_level = item.line_level;
    decoded.data_byte  = '0;
    unique case (item.operation)
      OP_RESET:      decoded.cmd = CMD_RESET;
      OP_WRITE: begin
        decoded.cmd       = CMD_WRITE;
        decoded.data_byte = item.data_byte;
      end
      OP_READ:       decoded.cmd = CMD_READ;
      OP_RESET_SKIP: decoded.cmd = CMD_RESET_SKIP;
      default:       decoded.cmd = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> count != 2'd0)
    else $error("pop from empty queue");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 2'd1)
    else $error("queue count did not grow on push");
`endif

endmodule

@@ rtl/core/owbm_seq.sv @@
// back end: bus timing sequencer, configuration registers and result register
`timescale 1ns / 1ps

module owbm_seq
  import owbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  owbm_cfg_if.sink   cfg,
  input  logic       q_valid,
  input  item_t      q_item,
  output logic       pop,
  owbm_out_if.source result
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_RST_WAIT,
    PH_RST_TAIL,
    PH_SLOT_LOW,
    PH_SLOT_WAIT,
    PH_SLOT_TAIL
  } phase_t;

  cfg_word_t cfg_regs [CFG_NUM];

  phase_t    phase, phase_next;
  cfg_word_t us_count, us_count_next;
  logic [2:0] bit_index, bit_index_next;
  byte_t     shift_data, shift_data_next;
  logic      skip_after_reset, skip_after_reset_next;
  logic      presence_missing, presence_missing_next;
  logic      drive_reg, drive_reg_next;
  logic      cur_read, cur_read_next;
  byte_t     last_read, last_read_next;
  logic      done_next;

  logic      out_valid;
  cfg_word_t len_raw;
  cfg_word_t len_eff;
  cfg_word_t cnt_inc;

  assign cfg.ready    = 1'b1;
  assign pop          = q_valid && (!out_valid || result.ready);
  assign result.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CFG_NUM; i++) begin
        cfg_regs[i] <= CFG_RESET[i];
      end
    end else if (cfg.valid) begin
      cfg_regs[cfg.index] <= cfg.data;
    end
  end

  // length of the running phase, zero stretched to one tick
  always_comb begin
    unique case (phase)
      PH_RST_LOW:   len_raw = cfg_regs[REG_RESET_LOW];
      PH_RST_WAIT:  len_raw = cfg_regs[REG_PRESENCE_SMP];
      PH_RST_TAIL:  len_raw = cfg_regs[REG_RESET_TAIL];
      PH_SLOT_LOW:  len_raw = (!cur_read && !shift_data[0]) ? cfg_regs[REG_WRITE_ZERO_LOW]
                                                            : cfg_regs[REG_SHORT_LOW];
      PH_SLOT_WAIT: len_raw = cfg_regs[REG_READ_SAMPLE];
      PH_SLOT_TAIL: begin
        if (cur_read) begin
          len_raw = READ_TAIL_US;
        end else begin
          len_raw = shift_data[0] ? cfg_regs[REG_WRITE_ONE_TAIL]
                                  : cfg_regs[REG_WRITE_ZERO_TL];
        end
      end
      default:      len_raw = 10'd1;
    endcase
  end

  assign len_eff = (len_raw == '0) ? 10'd1 : len_raw;
  assign cnt_inc = us_count + 10'd1;

  always_comb begin
    phase_next            = phase;
    us_count_next         = us_count;
    bit_index_next        = bit_index;
    shift_data_next       = shift_data;
    skip_after_reset_next = skip_after_reset;
    presence_missing_next = presence_missing;
    drive_reg_next        = drive_reg;
    cur_read_next         = cur_read;
    last_read_next        = last_read;
    done_next             = 1'b0;

    if (phase == PH_IDLE) begin
      unique case (q_item.cmd)
        CMD_RESET, CMD_RESET_SKIP: begin
          skip_after_reset_next = (q_item.cmd == CMD_RESET_SKIP);
          us_count_next         = '0;
          phase_next            = PH_RST_LOW;
          drive_reg_next        = 1'b1;
        end
        CMD_WRITE, CMD_READ: begin
          cur_read_next   = (q_item.cmd == CMD_READ);
          shift_data_next = q_item.data_byte;
          bit_index_next  = '0;
          us_count_next   = '0;
          phase_next      = PH_SLOT_LOW;
          drive_reg_next  = 1'b1;
        end
        default: ;
      endcase
    end else if (q_item.tick) begin
      if (cnt_inc >= len_eff || cnt_inc == '0) begin
        us_count_next = '0;
        unique case (phase)
          PH_RST_LOW: begin
            phase_next     = PH_RST_WAIT;
            drive_reg_next = 1'b0;
          end
          PH_RST_WAIT: begin
            presence_missing_next = q_item.line_level;
            phase_next            = PH_RST_TAIL;
          end
          PH_RST_TAIL: begin
            skip_after_reset_next = 1'b0;
            if (skip_after_reset && !presence_missing) begin
              cur_read_next   = 1'b0;
              shift_data_next = SKIP_ROM_CODE;
              bit_index_next  = '0;
              phase_next      = PH_SLOT_LOW;
              drive_reg_next  = 1'b1;
            end else begin
              phase_next = PH_IDLE;
              done_next  = 1'b1;
            end
          end
          PH_SLOT_LOW: begin
            drive_reg_next = 1'b0;
            phase_next     = cur_read ? PH_SLOT_WAIT : PH_SLOT_TAIL;
          end
          PH_SLOT_WAIT: begin
            shift_data_next = {q_item.line_level, shift_data[7:1]};
            phase_next      = PH_SLOT_TAIL;
          end
          PH_SLOT_TAIL: begin
            if (!cur_read) begin
              shift_data_next = {1'b0, shift_data[7:1]};
            end
            if (bit_index == 3'd7) begin
              if (cur_read) begin
                last_read_next = shift_data;
              end
              bit_index_next = '0;
              phase_next     = PH_IDLE;
              done_next      = 1'b1;
            end else begin
              bit_index_next = bit_index + 3'd1;
              phase_next     = PH_SLOT_LOW;
              drive_reg_next = 1'b1;
            end
          end
          default: begin
            phase_next     = PH_IDLE;
            drive_reg_next = 1'b0;
          end
        endcase
      end else begin
        us_count_next = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      us_count         <= '0;
      bit_index        <= '0;
      shift_data       <= '0;
      skip_after_reset <= 1'b0;
      presence_missing <= 1'b0;
      drive_reg        <= 1'b0;
      cur_read         <= 1'b0;
      last_read        <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (pop) begin
        phase            <= phase_next;
        us_count         <= us_count_next;
        bit_index        <= bit_index_next;
        shift_data       <= shift_data_next;
        skip_after_reset <= skip_after_reset_next;
        presence_missing <= presence_missing_next;
        drive_reg        <= drive_reg_next;
        cur_read         <= cur_read_next;
        last_read        <= last_read_next;
        out_valid        <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded with each processed item
  always_ff @(posedge clk) begin
    if (pop) begin
      result.drive_low     <= drive_reg_next;
      result.busy_res      <= (phase_next != PH_IDLE);
      result.done_res      <= done_next;
      result.received_byte <= last_read_next;
      result.no_presence   <= presence_missing_next;
    end
  end

`ifndef SYNTHESIS
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.done_res |-> !result.busy_res)
    else $error("done shown while still busy");
  a_drive_busy: assert property (@(posedge clk) disable iff (rst)
    drive_reg |-> phase != PH_IDLE)
    else $error("bus driven low while idle");
  a_hold_without_tick: assert property (@(posedge clk) disable iff (rst)
    pop && phase != PH_IDLE && !q_item.tick |=> phase == $past(phase))
    else $error("phase moved without a tick");
`endif

endmodule

@@ rtl/core/one_wire_bus_master.sv @@
// top level of the 1-wire bus master
`timescale 1ns / 1ps

// 1-wire bus master driven by one item per clock while results are taken. Each item carries
// the microsecond tick, the sampled bus level and an optional operation (reset with presence
// detect, write byte, read byte, reset then skip rom). Items enter a two-entry queue and the
// sequencer takes one item per cycle while results are taken. Each result is registered and
// appears in the cycle after its item reaches the sequencer from a queue entry. Every item
// gives exactly one result: drive_low for the open-drain pad, busy, a one-item done pulse,
// the last byte read and the presence flag. Operations that arrive while busy are dropped.
// Timing registers are written over the cfg channel, which is always ready; the user must
// write them only while the block is idle, and the block itself does not enforce it.
module one_wire_bus_master
  import owbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  owbm_in_if.sink    item,
  owbm_cfg_if.sink   cfg,
  owbm_out_if.source result
);

  logic  q_valid;
  item_t q_item;
  logic  pop;

  owbm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .q_valid (q_valid),
    .q_item  (q_item),
    .pop     (pop)
  );

  owbm_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_item  (q_item),
    .pop     (pop),
    .result  (result)
  );

endmodule
